[sv/assert_macros.svh]
// Assertion macros shared by the tile palette classifier RTL.
// Self-contained; expects a clock named aclk and an active-low reset named aresetn.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge, ignored while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

[sv/tpc_pkg.sv]
// Shared constants, palette tables and stage-to-stage types of the tile palette classifier.
// No dependencies.
package tpc_pkg;

    // Grid geometry.
    localparam int TILE_WIDTH   = 32;
    localparam int TILE_HEIGHT  = 28;
    localparam int GRID_COLUMNS = 6;
    localparam int GRID_ROWS    = 12;

    // Field widths.
    localparam int COL_W       = 10;
    localparam int ROW_W       = 9;
    localparam int COLOR_W     = 24;
    localparam int THRESH_W    = 10;
    localparam int OUT_COL_W   = 3;
    localparam int OUT_ROW_W   = 4;
    localparam int CLASS_W     = 3;
    localparam int S_TDATA_W   = 48;
    localparam int M_TDATA_W   = 16;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 10;

    // Field offsets inside tdata.
    localparam int S_COL_LSB   = 0;
    localparam int S_ROW_LSB   = S_COL_LSB + COL_W;
    localparam int S_COLOR_LSB = S_ROW_LSB + ROW_W;
    localparam int M_COL_LSB   = 0;
    localparam int M_ROW_LSB   = M_COL_LSB + OUT_COL_W;
    localparam int M_CLASS_LSB = M_ROW_LSB + OUT_ROW_W;

    // Configuration register indexes and reset values.
    localparam logic [CFG_ADDR_W-1:0] REG_REGION_LEFT     = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_REGION_BOTTOM   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_MATCH_THRESHOLD = 2'd2;
    localparam logic [COL_W-1:0]      RESET_REGION_LEFT   = 10'd52;
    localparam logic [ROW_W-1:0]      RESET_REGION_BOTTOM = 9'd41;
    localparam logic [THRESH_W-1:0]   RESET_THRESHOLD     = 10'd123;

    // Palettes and counters.
    localparam int PALETTES  = 5;
    localparam int ENTRIES   = 6;
    localparam int PAL_W     = $clog2(PALETTES + 1);
    localparam int COUNT_W   = 10;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [CLASS_W-1:0] CLASS_EMPTY = '0;

    // The tile that is always reported empty.
    localparam int MARK_ROW = 11;
    localparam int MARK_COL = 2;

    // Tile index and in-tile offset widths.
    localparam int TX_W = (GRID_COLUMNS > 1) ? $clog2(GRID_COLUMNS) : 1;
    localparam int TY_W = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
    localparam int H_W  = $clog2(TILE_WIDTH + 1);
    localparam int V_W  = $clog2(TILE_HEIGHT + 1);

    // Division by the tile size through a rounded-up reciprocal. The shift is
    // large enough that the quotient is exact for every 10-bit offset.
    localparam int DIV_SH  = 20;
    localparam int RECIP_X = ((1 << DIV_SH) + TILE_WIDTH - 1) / TILE_WIDTH;
    localparam int RECIP_Y = ((1 << DIV_SH) + TILE_HEIGHT - 1) / TILE_HEIGHT;
    localparam int PX_W    = COL_W + DIV_SH + 1;
    localparam int PY_W    = ROW_W + DIV_SH + 1;

    localparam int PAL_N = PALETTES * ENTRIES;

    localparam logic [COLOR_W-1:0] PAL_COLOR [PAL_N] = '{
        24'h840000, 24'h940000, 24'hA50000, 24'hBD0000, 24'hCE0000, 24'hDE0000,
        24'h0028C6, 24'h0040D6, 24'h0049E7, 24'h0020C6, 24'h0018B5, 24'h000894,
        24'h00C700, 24'h00D700, 24'h00E700, 24'h008600, 24'h009E00, 24'h218E21,
        24'hDED700, 24'hE7E700, 24'hD6CF00, 24'hCEBE00, 24'hBDA608, 24'hAD9608,
        24'h392418, 24'h636963, 24'hB5B6B5, 24'hEFEFDE, 24'h7B7973, 24'hFFFFFF
    };

    // Two garbage entries are disabled and never match.
    localparam logic PAL_ENABLE [PAL_N] = '{
        1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
        1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
        1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
        1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
        1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0
    };

    typedef logic [PALETTES-1:0][COUNT_W-1:0] counts_t;

    // Pixel located inside the grid, on its way to the counter memory.
    typedef struct packed {
        logic            valid;
        logic [TX_W-1:0] tx;
        logic [TY_W-1:0] ty;
        logic            first;
        logic            last;
        logic [PAL_W-1:0] pal;
    } tile_req_t;

    // Finished tile.
    typedef struct packed {
        logic                 valid;
        logic [OUT_COL_W-1:0] col;
        logic [OUT_ROW_W-1:0] row;
        logic [CLASS_W-1:0]   cls;
    } tile_res_t;

    // Palette number of a color, or PALETTES when no enabled entry matches.
    function automatic logic [PAL_W-1:0] match_palette(input logic [COLOR_W-1:0] color);
        logic [PAL_W-1:0] pal;
        pal = PAL_W'(PALETTES);
        for (int k = PAL_N - 1; k >= 0; k--) begin
            if (PAL_ENABLE[k] && (PAL_COLOR[k] == color)) begin
                pal = PAL_W'(k / ENTRIES);
            end
        end
        return pal;
    endfunction

endpackage

[sv/tile_palette_classifier_core.sv]
// Top level of the tile palette classifier: configuration registers, result register
// and assertions. Depends on tpc_pkg, tpc_locate, tpc_count and assert_macros.svh.

// Pixels enter at up to one per clock and pass through a five-stage pipeline: three
// stages locate the pixel on the 6 by 12 grid of 32 by 28 tiles and match its color,
// one takes the per-column palette counters read from a small RAM, updates them,
// writes them back and, on a tile's last pixel, scores the tile, and the last is the
// result register. The counter RAM is read whenever the counter stage does not stall
// and written for every valid pixel there, with the previous write forwarded, so
// consecutive pixels of the same tile never wait. The input stalls only when a
// tile-ending pixel reaches the counter stage while the previous result is still
// unread. After reset the counters read as zero at once; no clearing pass is needed.
module tile_palette_classifier_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Pixel requests.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [9:0] pixel_col, [18:10] pixel_row, [42:19] pixel_color, [47:43] zero
    input  logic [tpc_pkg::S_TDATA_W-1:0]  s_tdata,
    // Finished tiles.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [2:0] tile_col, [6:3] tile_row, [9:7] tile_class, [15:10] zero
    output logic [tpc_pkg::M_TDATA_W-1:0]  m_tdata,
    // Configuration writes.
    input  logic                          cfg_we,
    input  logic [tpc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [tpc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import tpc_pkg::*;
    `include "assert_macros.svh"

    logic [COL_W-1:0]    region_left_reg;
    logic [ROW_W-1:0]    region_bottom_reg;
    logic [THRESH_W-1:0] threshold_reg;

    tile_req_t req;
    tile_res_t res;
    tile_res_t out_reg;
    logic      stall;
    logic      out_busy;

    logic [CLASS_W-1:0] out_class;
    logic               out_marked;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            region_left_reg   <= RESET_REGION_LEFT;
            region_bottom_reg <= RESET_REGION_BOTTOM;
            threshold_reg     <= RESET_THRESHOLD;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_REGION_LEFT:     region_left_reg   <= COL_W'(cfg_wdata);
                REG_REGION_BOTTOM:   region_bottom_reg <= ROW_W'(cfg_wdata);
                REG_MATCH_THRESHOLD: threshold_reg     <= THRESH_W'(cfg_wdata);
                default: ;
            endcase
        end
    end

    assign s_tready = !stall;
    assign out_busy = out_reg.valid && !m_tready;

    tpc_locate u_locate (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .adv          (!stall),
        .in_valid     (s_tvalid && s_tready),
        .pixel_col    (s_tdata[S_COL_LSB +: COL_W]),
        .pixel_row    (s_tdata[S_ROW_LSB +: ROW_W]),
        .pixel_color  (s_tdata[S_COLOR_LSB +: COLOR_W]),
        .region_left  (region_left_reg),
        .region_bottom(region_bottom_reg),
        .req          (req)
    );

    tpc_count u_count (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (req),
        .out_busy (out_busy),
        .threshold(threshold_reg),
        .stall    (stall),
        .res      (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_reg.valid <= 1'b0;
        end else if (res.valid) begin
            out_reg.valid <= 1'b1;
        end else if (m_tready) begin
            out_reg.valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res.valid) begin
            out_reg.col <= res.col;
            out_reg.row <= res.row;
            out_reg.cls <= res.cls;
        end
    end

    assign m_tvalid = out_reg.valid;
    assign m_tdata  = {(M_TDATA_W - OUT_COL_W - OUT_ROW_W - CLASS_W)'(0),
                       out_reg.cls, out_reg.row, out_reg.col};

    assign out_class  = m_tdata[M_CLASS_LSB +: CLASS_W];
    assign out_marked = (m_tdata[M_COL_LSB +: OUT_COL_W] == OUT_COL_W'(MARK_COL))
                     && (m_tdata[M_ROW_LSB +: OUT_ROW_W] == OUT_ROW_W'(MARK_ROW));

    `ASSERT_ALWAYS(a_idle_after_reset, $past(!aresetn) |-> !m_tvalid, "result valid after reset")
    `ASSERT_CLK(a_stall_cause, !s_tready |-> (m_tvalid && !m_tready), "stall without cause")
    `ASSERT_CLK(a_class_range, m_tvalid |-> (out_class <= CLASS_W'(PALETTES)), "class out of range")
    `ASSERT_CLK(a_marked_empty, (m_tvalid && out_marked) |-> (out_class == CLASS_EMPTY), "marked tile")

endmodule

[sv/tpc_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies.
module tpc_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[sv/tpc_locate.sv]
// Locates each pixel on the tile grid and matches its color against the palettes.
// Three pipeline stages; depends on tpc_pkg.
module tpc_locate (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       adv,
    input  logic                       in_valid,
    input  logic [tpc_pkg::COL_W-1:0]   pixel_col,
    input  logic [tpc_pkg::ROW_W-1:0]   pixel_row,
    input  logic [tpc_pkg::COLOR_W-1:0] pixel_color,
    input  logic [tpc_pkg::COL_W-1:0]   region_left,
    input  logic [tpc_pkg::ROW_W-1:0]   region_bottom,
    output tpc_pkg::tile_req_t          req
);
    import tpc_pkg::*;

    // Stage 1: offsets from the grid origin and palette match.
    logic             v1_reg, inr1_reg;
    logic [COL_W-1:0] dx1_reg;
    logic [ROW_W-1:0] dy1_reg;
    logic [PAL_W-1:0] pal1_reg;

    // Stage 2: tile indexes.
    logic             v2_reg, inr2_reg;
    logic [COL_W-1:0] dx2_reg, qx2_reg;
    logic [ROW_W-1:0] dy2_reg, qy2_reg;
    logic [PAL_W-1:0] pal2_reg;

    // Stage 3: request to the counter stage.
    tile_req_t req_reg, req_next;

    logic [PX_W-1:0]  prod_x;
    logic [PY_W-1:0]  prod_y;
    logic [COL_W-1:0] h_full;
    logic [ROW_W-1:0] v_full;
    logic [H_W-1:0]   h;
    logic [V_W-1:0]   v;

    assign prod_x = PX_W'(dx1_reg) * PX_W'(RECIP_X);
    assign prod_y = PY_W'(dy1_reg) * PY_W'(RECIP_Y);

    always_comb begin
        h_full = dx2_reg - COL_W'(qx2_reg * COL_W'(TILE_WIDTH));
        v_full = dy2_reg - ROW_W'(qy2_reg * ROW_W'(TILE_HEIGHT));
        h      = h_full[H_W-1:0];
        v      = v_full[V_W-1:0];
        req_next.valid = v2_reg && inr2_reg
                      && (qx2_reg < COL_W'(GRID_COLUMNS))
                      && (qy2_reg < ROW_W'(GRID_ROWS));
        req_next.tx    = qx2_reg[TX_W-1:0];
        req_next.ty    = qy2_reg[TY_W-1:0];
        req_next.first = (h == '0) && (v == '0);
        req_next.last  = (h == H_W'(TILE_WIDTH - 1)) && (v == V_W'(TILE_HEIGHT - 1));
        req_next.pal   = pal2_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            req_reg.valid <= 1'b0;
        end else if (adv) begin
            v1_reg        <= in_valid;
            v2_reg        <= v1_reg;
            req_reg.valid <= req_next.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            inr1_reg <= (pixel_col >= region_left) && (pixel_row >= region_bottom);
            dx1_reg  <= pixel_col - region_left;
            dy1_reg  <= pixel_row - region_bottom;
            pal1_reg <= match_palette(pixel_color);

            inr2_reg <= inr1_reg;
            dx2_reg  <= dx1_reg;
            dy2_reg  <= dy1_reg;
            qx2_reg  <= prod_x[DIV_SH +: COL_W];
            qy2_reg  <= prod_y[DIV_SH +: ROW_W];
            pal2_reg <= pal1_reg;

            req_reg.tx    <= req_next.tx;
            req_reg.ty    <= req_next.ty;
            req_reg.first <= req_next.first;
            req_reg.last  <= req_next.last;
            req_reg.pal   <= req_next.pal;
        end
    end

    assign req = req_reg;

endmodule

[sv/tpc_count.sv]
// Per-column palette counters kept in a RAM, updated by read-modify-write, and tile scoring.
// Depends on tpc_pkg and tpc_ram.
module tpc_count (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  tpc_pkg::tile_req_t           req,
    input  logic                        out_busy,
    input  logic [tpc_pkg::THRESH_W-1:0] threshold,
    output logic                        stall,
    output tpc_pkg::tile_res_t           res
);
    import tpc_pkg::*;

    localparam int CW = PALETTES * COUNT_W;

    tile_req_t             req4_reg;
    logic                  fwd_hit_reg;
    counts_t               fwd_data_reg;
    logic [GRID_COLUMNS-1:0] vld_reg;

    logic                  wr_en;
    logic [CW-1:0]         rd_data;
    counts_t               counts_old;
    counts_t               counts_next;
    logic [CLASS_W-1:0]    cls;

    // A tile-ending pixel waits here while the previous result is still unread.
    assign stall = out_busy && req4_reg.valid && req4_reg.last;
    assign wr_en = req4_reg.valid && !stall;

    tpc_ram #(
        .WIDTH(CW),
        .DEPTH(GRID_COLUMNS)
    ) u_counts_ram (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(req4_reg.tx),
        .wr_data(CW'(counts_next)),
        .rd_en  (!stall),
        .rd_addr(req.tx),
        .rd_data(rd_data)
    );

    // The write of the previous cycle is not yet in the read data; an entry
    // never written since reset reads as all zero.
    always_comb begin
        if (fwd_hit_reg) begin
            counts_old = fwd_data_reg;
        end else if (vld_reg[req4_reg.tx]) begin
            counts_old = counts_t'(rd_data);
        end else begin
            counts_old = '0;
        end
    end

    always_comb begin
        for (int i = 0; i < PALETTES; i++) begin
            counts_next[i] = req4_reg.first ? '0 : counts_old[i];
            if ((req4_reg.pal == PAL_W'(i)) && (counts_next[i] != COUNT_MAX)) begin
                counts_next[i] = counts_next[i] + COUNT_W'(1);
            end
        end
    end

    always_comb begin
        cls = CLASS_EMPTY;
        for (int i = PALETTES - 1; i >= 0; i--) begin
            if (counts_next[i] > COUNT_W'(threshold)) begin
                cls = CLASS_W'(i + 1);
            end
        end
        if ((ROW_W'(req4_reg.ty) == ROW_W'(MARK_ROW))
                && (COL_W'(req4_reg.tx) == COL_W'(MARK_COL))) begin
            cls = CLASS_EMPTY;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req4_reg.valid <= 1'b0;
            fwd_hit_reg    <= 1'b0;
            vld_reg        <= '0;
        end else if (!stall) begin
            req4_reg.valid <= req.valid;
            fwd_hit_reg    <= wr_en && (req4_reg.tx == req.tx);
            if (wr_en) begin
                vld_reg[req4_reg.tx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!stall) begin
            req4_reg.tx    <= req.tx;
            req4_reg.ty    <= req.ty;
            req4_reg.first <= req.first;
            req4_reg.last  <= req.last;
            req4_reg.pal   <= req.pal;
            fwd_data_reg   <= counts_next;
        end
    end

    assign res.valid = req4_reg.valid && req4_reg.last && !stall;
    assign res.col   = OUT_COL_W'(req4_reg.tx);
    assign res.row   = OUT_ROW_W'(req4_reg.ty);
    assign res.cls   = cls;

endmodule

[bench/tile_palette_classifier_core_test.sv]
// Self-checking testbench for tile_palette_classifier_core: drives pixel requests,
// predicts every finished tile and compares the results in order.
// Depends on tpc_pkg and the classifier RTL only.
module tile_palette_classifier_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TILE_W    = tpc_pkg::TILE_WIDTH;
    localparam int TILE_H    = tpc_pkg::TILE_HEIGHT;
    localparam int GRID_COLS = tpc_pkg::GRID_COLUMNS;
    localparam int GRID_ROWS = tpc_pkg::GRID_ROWS;
    localparam int PALETTES  = tpc_pkg::PALETTES;
    localparam int ENTRIES   = tpc_pkg::ENTRIES;
    localparam int MAX_REPORTED = 10;
    localparam int SETTLE_CYCLES = 12;

    typedef enum logic [2:0] {
        TILE_EMPTY, TILE_RED, TILE_BLUE, TILE_GREEN, TILE_YELLOW, TILE_GARBAGE
    } tile_class_t;

    typedef struct packed {
        logic        valid;
        logic [2:0]  col;
        logic [3:0]  row;
        tile_class_t cls;
    } tile_result_t;

    localparam logic [23:0] PALETTE_RGB [PALETTES*ENTRIES] = '{
        24'h840000, 24'h940000, 24'hA50000, 24'hBD0000, 24'hCE0000, 24'hDE0000,
        24'h0028C6, 24'h0040D6, 24'h0049E7, 24'h0020C6, 24'h0018B5, 24'h000894,
        24'h00C700, 24'h00D700, 24'h00E700, 24'h008600, 24'h009E00, 24'h218E21,
        24'hDED700, 24'hE7E700, 24'hD6CF00, 24'hCEBE00, 24'hBDA608, 24'hAD9608,
        24'h392418, 24'h636963, 24'hB5B6B5, 24'hEFEFDE, 24'h7B7973, 24'hFFFFFF
    };
    localparam logic PALETTE_LIVE [PALETTES*ENTRIES] = '{
        1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
        1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
        1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
        1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
        1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0
    };

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [9:0]  cfg_wdata = '0;

    // Shadow of the block's registers and per-column palette counters.
    int          grid_left = 52;
    int          grid_bottom = 41;
    int          match_level = 123;
    logic [9:0]  tile_counts [GRID_COLS][PALETTES] = '{default: '0};

    tile_result_t expected_tiles [$];
    int          mismatches = 0;
    int          pixels_accepted = 0;
    int          tiles_checked = 0;
    int          settings_used = 1;
    bit          calm = 1'b0;
    int          hold_request = 0;
    int          hold_left = 0;
    int          stall_left = 0;

    tile_palette_classifier_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Updates the shadow counters for one pixel and returns the finished tile, if any.
    function automatic tile_result_t score_pixel(input logic [9:0] col, input logic [8:0] row,
                                                 input logic [23:0] color);
        tile_result_t res;
        int dx, dy, tx, ty, h, v, pal;
        res = '0;
        if (int'(col) < grid_left || int'(row) < grid_bottom) return res;
        dx = int'(col) - grid_left;
        dy = int'(row) - grid_bottom;
        tx = dx / TILE_W;
        ty = dy / TILE_H;
        if (tx >= GRID_COLS || ty >= GRID_ROWS) return res;
        h = dx % TILE_W;
        v = dy % TILE_H;
        if (h == 0 && v == 0) begin
            for (int i = 0; i < PALETTES; i++) tile_counts[tx][i] = '0;
        end
        pal = PALETTES;
        for (int k = 0; k < PALETTES*ENTRIES; k++) begin
            if (PALETTE_LIVE[k] && PALETTE_RGB[k] == color) begin
                pal = k / ENTRIES;
                break;
            end
        end
        // Counters saturate instead of wrapping.
        if (pal < PALETTES && tile_counts[tx][pal] != 10'h3FF)
            tile_counts[tx][pal] = tile_counts[tx][pal] + 10'd1;
        if (h != TILE_W - 1 || v != TILE_H - 1) return res;
        res.valid = 1'b1;
        res.col = 3'(tx);
        res.row = 4'(ty);
        res.cls = TILE_EMPTY;
        for (int i = PALETTES - 1; i >= 0; i--) begin
            if (int'(tile_counts[tx][i]) > match_level) res.cls = tile_class_t'(i + 1);
        end
        if (ty == tpc_pkg::MARK_ROW && tx == tpc_pkg::MARK_COL) res.cls = TILE_EMPTY;
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Mostly entries of the given palette, some of any palette, a few arbitrary colors.
    function automatic logic [23:0] pick_color(input int pal);
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return PALETTE_RGB[pal*ENTRIES + $urandom_range(0, ENTRIES - 1)];
        if (r < 85) return PALETTE_RGB[$urandom_range(0, PALETTES*ENTRIES - 1)];
        return 24'($urandom);
    endfunction

    task automatic send_pixel(input logic [9:0] col, input logic [8:0] row,
                              input logic [23:0] color);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata <= {5'b0, color, row, col};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_tile_pixel(input int tx, input int ty, input int h, input int v,
                                   input logic [23:0] color);
        send_pixel(10'(grid_left + tx*TILE_W + h), 9'(grid_bottom + ty*TILE_H + v), color);
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        // The loop waits on the clock first, so that a tile whose pixel was just accepted is already expected.
        @(posedge aclk);
        while (expected_tiles.size() != 0) @(posedge aclk);
    endtask

    // Registers change only with the pipeline empty, including pixels that end no tile.
    task automatic set_config(input logic [9:0] left, input logic [8:0] bottom,
                              input logic [9:0] level);
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= tpc_pkg::REG_REGION_LEFT;
        cfg_wdata <= left;
        @(posedge aclk);
        cfg_addr <= tpc_pkg::REG_REGION_BOTTOM;
        cfg_wdata <= 10'(bottom);
        @(posedge aclk);
        cfg_addr <= tpc_pkg::REG_MATCH_THRESHOLD;
        cfg_wdata <= level;
        @(posedge aclk);
        cfg_we <= 1'b0;
        grid_left = int'(left);
        grid_bottom = int'(bottom);
        match_level = int'(level);
        settings_used++;
    endtask

    always @(posedge aclk) begin : pixel_monitor
        tile_result_t res;
        if (aresetn && s_tvalid && s_tready) begin
            pixels_accepted++;
            res = score_pixel(s_tdata[9:0], s_tdata[18:10], s_tdata[42:19]);
            if (res.valid) expected_tiles = {expected_tiles, res};
        end
    end

    always @(posedge aclk) begin : result_check
        tile_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                tiles_checked++;
                if (expected_tiles.size() == 0) begin
                    if (mismatches < MAX_REPORTED)
                        $display("unexpected tile col %0d row %0d class %0d",
                                 m_tdata[2:0], m_tdata[6:3], m_tdata[9:7]);
                    mismatches++;
                end else begin
                    want = expected_tiles.pop_front();
                    if (m_tdata[2:0] !== want.col || m_tdata[6:3] !== want.row ||
                        m_tdata[9:7] !== want.cls) begin
                        if (mismatches < MAX_REPORTED)
                            $display("mismatch col/row/class: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                                     want.col, want.row, want.cls,
                                     m_tdata[2:0], m_tdata[6:3], m_tdata[9:7]);
                        mismatches++;
                    end
                end
            end
            // A long hold-off takes priority over the ordinary random stalls.
            if (hold_request > 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                stall_left = calm ? 0 : pick_gap();
            end
        end
    end

    task automatic test_reset_defaults();
        // Registers untouched: two red pixels stay far below the default threshold.
        send_tile_pixel(0, 0, 0, 0, 24'h840000);
        send_tile_pixel(0, 0, TILE_W - 1, TILE_H - 1, 24'h840000);
    endtask

    task automatic test_directed_cases();
        set_config(10'd52, 9'd41, 10'd0);
        send_tile_pixel(0, 0, 0, 0, 24'h840000);
        send_tile_pixel(0, 0, TILE_W - 1, TILE_H - 1, 24'h0028C6);
        send_tile_pixel(4, 0, 0, 0, 24'h0028C6);
        send_tile_pixel(4, 0, TILE_W - 1, TILE_H - 1, 24'h000894);
        send_tile_pixel(1, 1, 0, 0, 24'h218E21);
        send_tile_pixel(1, 1, TILE_W - 1, TILE_H - 1, 24'h00C700);
        send_tile_pixel(3, 2, 0, 0, 24'hDED700);
        send_tile_pixel(3, 2, TILE_W - 1, TILE_H - 1, 24'hAD9608);
        send_tile_pixel(5, 11, 0, 0, 24'h636963);
        send_tile_pixel(5, 11, TILE_W - 1, TILE_H - 1, 24'hEFEFDE);
        // The marked tile reports empty even with a winning palette.
        send_tile_pixel(2, 11, 0, 0, 24'h840000);
        send_tile_pixel(2, 11, TILE_W - 1, TILE_H - 1, 24'h840000);
        // Disabled garbage entries count for nothing.
        send_tile_pixel(1, 0, 0, 0, 24'h392418);
        send_tile_pixel(1, 0, TILE_W - 1, TILE_H - 1, 24'hFFFFFF);
        // A last pixel with no first pixel reports whatever the column holds.
        send_tile_pixel(3, 5, TILE_W - 1, TILE_H - 1, 24'h00E700);
        send_pixel(10'd51, 9'd41, 24'h840000);
        send_pixel(10'd52, 9'd40, 24'h840000);
        send_pixel(10'd244, 9'd68, 24'h840000);
        send_pixel(10'd83, 9'd377, 24'h840000);
        send_pixel(10'd0, 9'd0, 24'h000000);
        send_pixel(10'd639, 9'd479, 24'hFFFFFF);
    endtask

    task automatic test_grid_edges();
        set_config(10'd0, 9'd0, 10'd896);
        send_tile_pixel(0, 0, 0, 0, 24'h840000);
        send_tile_pixel(0, 0, TILE_W - 1, TILE_H - 1, 24'h840000);
        send_tile_pixel(5, 11, TILE_W - 1, TILE_H - 1, 24'hDED700);
        send_pixel(10'd192, 9'd27, 24'h840000);
        set_config(10'd447, 9'd143, 10'd0);
        send_tile_pixel(5, 11, TILE_W - 1, TILE_H - 1, 24'h0049E7);
        send_pixel(10'd639, 9'd479, 24'h0049E7);
        // Only the single corner pixel lies inside this grid, so nothing can finish.
        set_config(10'd639, 9'd479, 10'd0);
        send_pixel(10'd639, 9'd479, 24'h00C700);
        repeat (30) send_pixel(10'($urandom_range(0, 639)), 9'($urandom_range(0, 479)),
                               24'($urandom));
    endtask

    task automatic test_full_tile();
        set_config(10'd100, 9'd60, 10'd500);
        for (int v = 0; v < TILE_H; v++)
            for (int h = 0; h < TILE_W; h++)
                send_tile_pixel(2, 3, h, v, pick_color(TILE_GREEN - 1));
    endtask

    // Builds on the column left by the full tile: with no first pixel in between,
    // the green count keeps growing until it hits its ceiling.
    task automatic test_counter_saturation();
        set_config(10'd100, 9'd60, 10'd1022);
        calm = 1'b1;
        repeat (500) send_tile_pixel(2, 3, $urandom_range(1, TILE_W - 2),
                                     $urandom_range(0, TILE_H - 1), 24'h00C700);
        send_tile_pixel(2, 3, TILE_W - 1, TILE_H - 1, 24'h00C700);
        // The saturated count can never exceed the largest threshold.
        set_config(10'd100, 9'd60, 10'h3FF);
        send_tile_pixel(2, 3, TILE_W - 1, TILE_H - 1, 24'h00C700);
        calm = 1'b0;
    endtask

    task automatic test_backpressure();
        set_config(10'd0, 9'd0, 10'd2);
        calm = 1'b1;
        hold_request = 400;
        repeat (40) send_tile_pixel($urandom_range(0, GRID_COLS - 1),
                                    $urandom_range(0, GRID_ROWS - 1), TILE_W - 1, TILE_H - 1,
                                    pick_color($urandom_range(0, PALETTES - 1)));
        calm = 1'b0;
    endtask

    task automatic test_random_tiles(input int pixel_budget);
        int sent, runs, tx, ty, pal, len;
        logic [9:0] level;
        sent = 0;
        while (sent < pixel_budget) begin
            level = ($urandom_range(0, 9) == 0) ? 10'($urandom_range(0, 896))
                                                 : 10'($urandom_range(0, 20));
            set_config(10'($urandom_range(0, 447)), 9'($urandom_range(0, 143)), level);
            calm = ($urandom_range(0, 4) == 0);
            runs = $urandom_range(4, 12);
            repeat (runs) begin
                tx = $urandom_range(0, GRID_COLS - 1);
                ty = $urandom_range(0, GRID_ROWS - 1);
                pal = $urandom_range(0, PALETTES - 1);
                len = $urandom_range(2, 40);
                if ($urandom_range(0, 9) != 0) send_tile_pixel(tx, ty, 0, 0, pick_color(pal));
                repeat (len) begin
                    if ($urandom_range(0, 9) == 0)
                        send_pixel(10'($urandom_range(0, 639)), 9'($urandom_range(0, 479)),
                                   24'($urandom));
                    else
                        send_tile_pixel(tx, ty, $urandom_range(0, TILE_W - 1),
                                        $urandom_range(0, TILE_H - 1), pick_color(pal));
                end
                send_tile_pixel(tx, ty, TILE_W - 1, TILE_H - 1, pick_color(pal));
                sent += len + 2;
                // Now and then the sender stops until every tile has come back.
                if ($urandom_range(0, 15) == 0) wait_for_results();
            end
            calm = 1'b0;
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_directed_cases();
        test_grid_edges();
        test_full_tile();
        test_counter_saturation();
        test_backpressure();
        test_random_tiles(450);
        wait_for_results();
        repeat (20) @(posedge aclk);
        $display("summary: %0d pixel requests, %0d tiles checked, %0d register settings",
                 pixels_accepted, tiles_checked, settings_used);
        $display("summary: %0d mismatches, %0d tiles still outstanding",
                 mismatches, expected_tiles.size());
        if (mismatches == 0 && expected_tiles.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

endmodule
